// ----- rtl/core/rma_pkg.sv -----
package rma_pkg;

    // Datapath and configuration widths.
    localparam int DATA_W  = 64;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int HALF_W  = DATA_W / 2;
    localparam int EXP_W   = 7;
    localparam int CMD_W   = 2;
    localparam int LANE_W  = 3;
    localparam int USER_W  = 8;
    localparam int N_EXP   = 8;
    localparam int LANES   = 8;

    localparam logic [EXP_W-1:0] EXP_MIN = EXP_W'(2);
    localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(DATA_W);

    localparam logic [EXP_W-1:0] EXP_RESET [N_EXP] = '{
        7'd64, 7'd63, 7'd61, 7'd59, 7'd55, 7'd53, 7'd47, 7'd43
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2
    } cmd_t;

    // Load enables of the two multiplier stages.
    typedef struct packed {
        logic pp;
        logic sum;
    } mul_en_t;

endpackage

// ----- rtl/core/rma_mul.sv -----
// Two-stage 64x64 multiplier: four 32x32 partial products, then one combining add.
module rma_mul (
    input  logic                         clk,
    input  rma_pkg::mul_en_t             en,
    input  logic [rma_pkg::DATA_W-1:0]   a,
    input  logic [rma_pkg::DATA_W-1:0]   b,
    output logic [rma_pkg::PROD_W-1:0]   prod
);

    localparam int HW = rma_pkg::HALF_W;
    localparam int DW = rma_pkg::DATA_W;
    localparam int PW = rma_pkg::PROD_W;

    logic [DW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;

    always_comb
    begin
        prod_next = {p11_reg, p00_reg}
                  + (PW'(p01_reg) << HW)
                  + (PW'(p10_reg) << HW);
    end

    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            p00_reg <= DW'(a[HW-1:0])  * DW'(b[HW-1:0]);
            p01_reg <= DW'(a[HW-1:0])  * DW'(b[DW-1:HW]);
            p10_reg <= DW'(a[DW-1:HW]) * DW'(b[HW-1:0]);
            p11_reg <= DW'(a[DW-1:HW]) * DW'(b[DW-1:HW]);
        end
        if (en.sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/rns_mersenne_alu.sv -----
// Path: an accepted beat goes through stages 1 to 5 and then the output register.
// Throughput: one beat per cycle unless the output stalls; every stage holds its own valid
// bit, so bubbles fill up while the output is stalled and nothing is dropped or repeated.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and loads the
// lane exponents with 64, 63, 61, 59, 55, 53, 47 and 43.
module rns_mersenne_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [rma_pkg::LANE_W-1:0]    cfg_idx,
    input  logic [rma_pkg::EXP_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*rma_pkg::DATA_W-1:0]  s_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [rma_pkg::USER_W-1:0]    s_tuser,   // cmd [1:0], lane [4:2], zero [7:5]
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rma_pkg::DATA_W-1:0]    m_tdata    // result [63:0]
);

    localparam int DW = rma_pkg::DATA_W;
    localparam int PW = rma_pkg::PROD_W;
    localparam int EW = rma_pkg::EXP_W;

    // The lane exponents. The user must see that they are only written while the pipeline
    // is empty, so stage 1 may read them directly; the block itself does not enforce it.
    logic [EW-1:0] lane_exp_reg [rma_pkg::N_EXP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rma_pkg::N_EXP; i++)
            begin
                lane_exp_reg[i] <= rma_pkg::EXP_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            lane_exp_reg[cfg_idx] <= cfg_wdata;
        end
    end

    // Stall chain. A stage loads whenever it is empty or the stage after it loads, so a
    // stalled output only backs up as far as the first bubble.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic en1, en2, en3, en4, en5, eno;
    logic s_fire;

    assign eno      = !vo_reg || m_tready;
    assign en5      = !v5_reg || eno;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_fire;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (eno) vo_reg <= v5_reg;
        end
    end

    // Stage 1: look up and clamp the lane exponent, build the mask 2^k-1 and cut
    // both operands to k bits. Unknown commands and lanes beyond the lane count
    // are flagged to give zero.
    logic [rma_pkg::CMD_W-1:0]  in_cmd;
    logic [rma_pkg::LANE_W-1:0] in_lane;
    logic [EW-1:0]              raw_exp;
    logic [EW-1:0]              k1_next;
    logic [DW-1:0]              m1_next;
    logic                       z1_next;

    logic [EW-1:0]       k1_reg, k2_reg, k3_reg, k4_reg;
    logic [DW-1:0]       m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    rma_pkg::cmd_t       c1_reg, c2_reg, c3_reg, c4_reg;
    logic                z1_reg, z2_reg, z3_reg, z4_reg, z5_reg;
    logic [DW-1:0]       a1_reg, b1_reg;

    assign in_cmd  = s_tuser[rma_pkg::CMD_W-1:0];
    assign in_lane = s_tuser[rma_pkg::CMD_W +: rma_pkg::LANE_W];
    assign raw_exp = lane_exp_reg[in_lane];

    always_comb
    begin
        if (raw_exp < rma_pkg::EXP_MIN)
        begin
            k1_next = rma_pkg::EXP_MIN;
        end
        else if (raw_exp > rma_pkg::EXP_MAX)
        begin
            k1_next = rma_pkg::EXP_MAX;
        end
        else
        begin
            k1_next = raw_exp;
        end
        m1_next = (k1_next == rma_pkg::EXP_MAX) ? '1 : ((DW'(1) << k1_next) - DW'(1));
        z1_next = (32'(in_lane) >= rma_pkg::LANES)
               || !(in_cmd == rma_pkg::CMD_ADD || in_cmd == rma_pkg::CMD_SUB
                    || in_cmd == rma_pkg::CMD_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            k1_reg <= k1_next;
            m1_reg <= m1_next;
            c1_reg <= rma_pkg::cmd_t'(in_cmd);
            z1_reg <= z1_next;
            a1_reg <= s_tdata[DW-1:0] & m1_next;
            b1_reg <= s_tdata[2*DW-1:DW] & m1_next;
        end
    end

    // Stage 2: the partial products start in the multiplier. The subtraction is done
    // here with its end-around borrow; add just carries both operands on.
    logic [DW-1:0] x2_next, y2_next;
    logic [DW-1:0] x2_reg, y2_reg, x3_reg, y3_reg;

    always_comb
    begin
        if (c1_reg == rma_pkg::CMD_SUB)
        begin
            x2_next = a1_reg - b1_reg - DW'(a1_reg < b1_reg);
            y2_next = '0;
        end
        else
        begin
            x2_next = a1_reg;
            y2_next = b1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            k2_reg <= k1_reg;
            m2_reg <= m1_reg;
            c2_reg <= c1_reg;
            z2_reg <= z1_reg;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
        end
        if (en3)
        begin
            k3_reg <= k2_reg;
            m3_reg <= m2_reg;
            c3_reg <= c2_reg;
            z3_reg <= z2_reg;
            x3_reg <= x2_reg;
            y3_reg <= y2_reg;
        end
    end

    // Stages 2 and 3: the double-width product.
    rma_pkg::mul_en_t mul_en;
    logic [PW-1:0]    prod3;

    assign mul_en.pp  = en2;
    assign mul_en.sum = en3;

    rma_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (a1_reg),
        .b    (b1_reg),
        .prod (prod3)
    );

    // Stage 4: a product is split into its low k bits and the part from bit k upward.
    // Both then go through the same end-around carry fold as an add.
    logic [PW-1:0] prod_shr;
    logic [DW-1:0] x4_next, y4_next;
    logic [DW-1:0] x4_reg, y4_reg;

    always_comb
    begin
        prod_shr = prod3 >> k3_reg;
        if (c3_reg == rma_pkg::CMD_MUL)
        begin
            x4_next = prod3[DW-1:0] & m3_reg;
            y4_next = prod_shr[DW-1:0];
        end
        else
        begin
            x4_next = x3_reg;
            y4_next = y3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            k4_reg <= k3_reg;
            m4_reg <= m3_reg;
            c4_reg <= c3_reg;
            z4_reg <= z3_reg;
            x4_reg <= x4_next;
            y4_reg <= y4_next;
        end
    end

    // Stage 5: add the two parts. The carry out of bit k (bit 64 when k is 64) is
    // kept for the end-around step. A difference has no carry to fold.
    logic [DW:0]   sum5;
    logic [DW-1:0] t5_next, t5_reg;
    logic          c5_next, c5_reg;

    always_comb
    begin
        sum5    = {1'b0, x4_reg} + {1'b0, y4_reg};
        t5_next = sum5[DW-1:0] & m4_reg;
        c5_next = (c4_reg != rma_pkg::CMD_SUB) && sum5[k4_reg];
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            m5_reg <= m4_reg;
            z5_reg <= z4_reg;
            t5_reg <= t5_next;
            c5_reg <= c5_next;
        end
    end

    // Output register: add the end-around carry, map the second form of zero,
    // 2^k-1, to 0 and give 0 for flagged beats.
    logic [DW-1:0] r_sum;
    logic [DW-1:0] res_next, res_reg;

    always_comb
    begin
        r_sum = t5_reg + DW'(c5_reg);
        if (z5_reg || r_sum == m5_reg)
        begin
            res_next = '0;
        end
        else
        begin
            res_next = r_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eno)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = res_reg;

endmodule

// ----- rtl/core/rma_checker.sv -----
module rma_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rma_pkg::DATA_W-1:0]    m_tdata
);

    // A stalled result beat stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Back-pressure on the input can only come from a stalled output.
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled output");

    // A normalized residue is at most 2^64-2, so it is never all ones.
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != '1)
        else $error("result is not normalized");

    // Reset empties the pipeline by the next edge.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result beat present during reset");

endmodule

bind rns_mersenne_alu rma_checker u_rma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
